[hw/rtl/mm_pkg.sv]
package mm_pkg;

    localparam int MAX_DIM   = 8;
    localparam int IDX_W     = $clog2(MAX_DIM);
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int DIM_W     = 4;
    localparam int ELEM_W    = 16;
    localparam int PROD_W    = 2 * ELEM_W;
    localparam int ACC_W     = 35;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [MODE_W-1:0] MODE_LOAD_A  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_B  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 2'd2;

    typedef struct packed {
        logic [IDX_W-1:0] b_addr;
        logic [IDX_W-1:0] rd_addr;
        logic             mul_en;
        logic             acc_en;
        logic             acc_first;
        logic             shift;
    } cell_ctl_t;

    // last valid index of a dimension, with 0 taken as 1 and anything above MAX_DIM as MAX_DIM
    function automatic logic [IDX_W-1:0] dim_last(input logic [DIM_W-1:0] v);
        logic [IDX_W-1:0] res;
        if (v == '0)
        begin
            res = '0;
        end
        else if (v > DIM_W'(MAX_DIM))
        begin
            res = IDX_W'(MAX_DIM - 1);
        end
        else
        begin
            res = IDX_W'(v - 1'b1);
        end
        return res;
    endfunction

endpackage

[hw/rtl/mm_cell.sv]
module mm_cell (
    input  logic                             clk,
    input  mm_pkg::cell_ctl_t                ctl,
    input  logic                             b_sel,
    input  logic signed [mm_pkg::ELEM_W-1:0] elem,
    input  logic signed [mm_pkg::ELEM_W-1:0] a_val,
    input  logic signed [mm_pkg::ACC_W-1:0]  acc_in,
    output logic signed [mm_pkg::ACC_W-1:0]  acc_out
);

    // one column of B lives in each cell
    logic signed [mm_pkg::ELEM_W-1:0] b_mem [mm_pkg::MAX_DIM];
    logic signed [mm_pkg::ELEM_W-1:0] b_rd_reg;
    logic signed [mm_pkg::PROD_W-1:0] prod_reg;
    logic signed [mm_pkg::ACC_W-1:0]  acc_reg;

    always_ff @(posedge clk)
    begin
        if (b_sel)
        begin
            b_mem[ctl.b_addr] <= elem;
        end
        b_rd_reg <= b_mem[ctl.rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            prod_reg <= a_val * b_rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            acc_reg <= acc_in;
        end
        else if (ctl.acc_en)
        begin
            if (ctl.acc_first)
            begin
                acc_reg <= mm_pkg::ACC_W'(prod_reg);
            end
            else
            begin
                acc_reg <= acc_reg + mm_pkg::ACC_W'(prod_reg);
            end
        end
    end

    assign acc_out = acc_reg;

endmodule

[hw/rtl/matrix_multiply_top.sv]
// Load word (A or B element): busy stays low, no result.
// Compute word: per result row, nk MAC issues into the cell row, then a flush through the
// read/multiply/accumulate registers, then nc shifts moving results out of the chain;
// one result word per cycle during the shift, strobed by valid; busy until the last is out.
// Reset: asynchronous active low; dimensions return to 8, stores keep no defined contents.
module matrix_multiply_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [mm_pkg::MODE_W-1:0]           mode,
    input  logic [mm_pkg::IDX_W-1:0]            elem_row,
    input  logic [mm_pkg::IDX_W-1:0]            elem_col,
    input  logic signed [mm_pkg::ELEM_W-1:0]    elem_value,
    input  logic                                cfg_we,
    input  logic [mm_pkg::CFG_IDX_W-1:0]        cfg_idx,
    input  logic [mm_pkg::DIM_W-1:0]            cfg_data,
    output logic                                valid,
    output logic [mm_pkg::IDX_W-1:0]            prod_row,
    output logic [mm_pkg::IDX_W-1:0]            prod_col,
    output logic signed [mm_pkg::ACC_W-1:0]     prod_value,
    output logic                                last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_DRAIN,
        S_EMIT
    } state_t;

    state_t                           state_reg;
    logic [mm_pkg::DIM_W-1:0]         rows_a_reg;
    logic [mm_pkg::DIM_W-1:0]         inner_dim_reg;
    logic [mm_pkg::DIM_W-1:0]         cols_b_reg;
    logic [mm_pkg::IDX_W-1:0]         r_reg;
    logic [mm_pkg::IDX_W-1:0]         k_reg;
    logic [mm_pkg::IDX_W-1:0]         c_reg;
    logic                             rd_vld_reg;
    logic                             rd_first_reg;
    logic                             mul_vld_reg;
    logic                             mul_first_reg;
    logic                             valid_reg;
    logic [mm_pkg::IDX_W-1:0]         prod_row_reg;
    logic [mm_pkg::IDX_W-1:0]         prod_col_reg;
    logic signed [mm_pkg::ACC_W-1:0]  prod_value_reg;
    logic                             last_reg;

    logic signed [mm_pkg::ELEM_W-1:0] a_mem [mm_pkg::MAX_DIM * mm_pkg::MAX_DIM];
    logic signed [mm_pkg::ELEM_W-1:0] a_rd_reg;

    logic                             accept;
    logic                             load_a;
    logic                             load_b;
    logic                             issue;
    logic [mm_pkg::IDX_W-1:0]         nr_last;
    logic [mm_pkg::IDX_W-1:0]         nk_last;
    logic [mm_pkg::IDX_W-1:0]         nc_last;
    mm_pkg::cell_ctl_t                ctl;
    logic signed [mm_pkg::ACC_W-1:0]  chain [mm_pkg::MAX_DIM + 1];

    assign busy    = (state_reg != S_IDLE);
    assign accept  = start && !busy;
    assign load_a  = accept && (mode == mm_pkg::MODE_LOAD_A);
    assign load_b  = accept && (mode == mm_pkg::MODE_LOAD_B);
    assign issue   = (state_reg == S_ISSUE);
    assign nr_last = mm_pkg::dim_last(rows_a_reg);
    assign nk_last = mm_pkg::dim_last(inner_dim_reg);
    assign nc_last = mm_pkg::dim_last(cols_b_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg    <= mm_pkg::DIM_W'(mm_pkg::MAX_DIM);
            inner_dim_reg <= mm_pkg::DIM_W'(mm_pkg::MAX_DIM);
            cols_b_reg    <= mm_pkg::DIM_W'(mm_pkg::MAX_DIM);
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                mm_pkg::REG_ROWS_A:    rows_a_reg    <= cfg_data;
                mm_pkg::REG_INNER_DIM: inner_dim_reg <= cfg_data;
                mm_pkg::REG_COLS_B:    cols_b_reg    <= cfg_data;
                default:               ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_a)
        begin
            a_mem[{elem_row, elem_col}] <= elem_value;
        end
        a_rd_reg <= a_mem[{r_reg, k_reg}];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            r_reg          <= '0;
            k_reg          <= '0;
            c_reg          <= '0;
            rd_vld_reg     <= 1'b0;
            rd_first_reg   <= 1'b0;
            mul_vld_reg    <= 1'b0;
            mul_first_reg  <= 1'b0;
            valid_reg      <= 1'b0;
            prod_row_reg   <= '0;
            prod_col_reg   <= '0;
            prod_value_reg <= '0;
            last_reg       <= 1'b0;
        end
        else
        begin
            rd_vld_reg    <= issue;
            rd_first_reg  <= issue && (k_reg == '0);
            mul_vld_reg   <= rd_vld_reg;
            mul_first_reg <= rd_first_reg;
            valid_reg     <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && (mode == mm_pkg::MODE_COMPUTE))
                    begin
                        r_reg     <= '0;
                        k_reg     <= '0;
                        c_reg     <= '0;
                        state_reg <= S_ISSUE;
                    end
                end
                S_ISSUE:
                begin
                    if (k_reg == nk_last)
                    begin
                        state_reg <= S_DRAIN;
                    end
                    else
                    begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                S_DRAIN:
                begin
                    if (!rd_vld_reg && !mul_vld_reg)
                    begin
                        c_reg     <= '0;
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    valid_reg      <= 1'b1;
                    prod_row_reg   <= r_reg;
                    prod_col_reg   <= c_reg;
                    prod_value_reg <= chain[0];
                    last_reg       <= (r_reg == nr_last) && (c_reg == nc_last);
                    if (c_reg == nc_last)
                    begin
                        c_reg <= '0;
                        k_reg <= '0;
                        if (r_reg == nr_last)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            r_reg     <= r_reg + 1'b1;
                            state_reg <= S_ISSUE;
                        end
                    end
                    else
                    begin
                        c_reg <= c_reg + 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        ctl.b_addr    = elem_row;
        ctl.rd_addr   = k_reg;
        ctl.mul_en    = rd_vld_reg;
        ctl.acc_en    = mul_vld_reg;
        ctl.acc_first = mul_first_reg;
        ctl.shift     = (state_reg == S_EMIT);
    end

    assign chain[mm_pkg::MAX_DIM] = '0;

    for (genvar i = 0; i < mm_pkg::MAX_DIM; i++)
    begin : g_cell
        mm_cell u_cell (
            .clk     (clk),
            .ctl     (ctl),
            .b_sel   (load_b && (elem_col == mm_pkg::IDX_W'(i))),
            .elem    (elem_value),
            .a_val   (a_rd_reg),
            .acc_in  (chain[i + 1]),
            .acc_out (chain[i])
        );
    end

    assign valid      = valid_reg;
    assign prod_row   = prod_row_reg;
    assign prod_col   = prod_col_reg;
    assign prod_value = prod_value_reg;
    assign last       = last_reg;

endmodule
